FILE: hdl/tah_pkg.sv
// ----------------------------------------------------------------------------
// tah_pkg
// Shared types and codes of the temperature alarm: alarm levels, opcodes,
// configuration register indexes and the state word.
// ----------------------------------------------------------------------------
`default_nettype none

package tah_pkg;

  // Result level codes as seen on the output port
  localparam logic [1:0] LVL_NORMAL   = 2'd0;
  localparam logic [1:0] LVL_WARNING  = 2'd1;
  localparam logic [1:0] LVL_CRITICAL = 2'd2;
  localparam logic [1:0] LVL_FAULT    = 2'd3;

  // Input opcodes
  localparam logic OP_READING = 1'b0;
  localparam logic OP_RESET   = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BAD   = 3'd5;

  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  // Alarm state machine, one-hot
  typedef enum logic [3:0] {
    ST_NORMAL   = 4'b0001,
    ST_WARNING  = 4'b0010,
    ST_CRITICAL = 4'b0100,
    ST_FAULT    = 4'b1000
  } level_t;

  // State carried from one word to the next
  typedef struct packed {
    level_t           level;
    logic [CNT_W-1:0] count;
  } tah_state_t;

  // Map the one-hot state to the output level code
  function automatic logic [1:0] level_code(input level_t lvl);
    logic [1:0] code;
    unique case (lvl)
      ST_NORMAL:   code = LVL_NORMAL;
      ST_WARNING:  code = LVL_WARNING;
      ST_CRITICAL: code = LVL_CRITICAL;
      ST_FAULT:    code = LVL_FAULT;
      default:     code = LVL_FAULT;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tah_eval.sv
// ----------------------------------------------------------------------------
// tah_eval
// Next-state logic for one word: reset command, checksum error run, fault latch and the
// normal / warning / critical transitions with hysteresis.
// ----------------------------------------------------------------------------
`default_nettype none

module tah_eval
  import tah_pkg::*;
#(
  parameter int TEMP_BITS = 12
) (
  input  tah_state_t                    cur,
  input  logic                          opcode,
  input  logic                          checksum_ok,
  input  logic signed [TEMP_BITS-1:0]   temperature,
  input  logic signed [TEMP_BITS-1:0]   warn_high,
  input  logic signed [TEMP_BITS-1:0]   warn_low,
  input  logic signed [TEMP_BITS-1:0]   crit_high,
  input  logic signed [TEMP_BITS-1:0]   crit_low,
  input  logic        [CNT_W-1:0]       hysteresis,
  input  logic        [CNT_W-1:0]       max_bad_checksums,
  output tah_state_t                    nxt
);

  // Two spare bits keep threshold +/- hysteresis in range down to 8-bit readings
  localparam int CMP_W = TEMP_BITS + 2;

  logic signed [CMP_W-1:0] t_x;
  logic signed [CMP_W-1:0] wh_x;
  logic signed [CMP_W-1:0] wl_x;
  logic signed [CMP_W-1:0] ch_x;
  logic signed [CMP_W-1:0] cl_x;
  logic signed [CMP_W-1:0] h_x;
  logic                    crit_hit;
  logic                    warn_hit;
  logic                    warn_clear;
  logic                    crit_clear;
  logic [CNT_W-1:0]        count_inc;

  // Sign-extend everything to the comparison width
  assign t_x  = CMP_W'(temperature);
  assign wh_x = CMP_W'(warn_high);
  assign wl_x = CMP_W'(warn_low);
  assign ch_x = CMP_W'(crit_high);
  assign cl_x = CMP_W'(crit_low);
  assign h_x  = $signed({{(CMP_W-CNT_W){1'b0}}, hysteresis});

  assign crit_hit   = (t_x >= ch_x) || (t_x <= cl_x);
  assign warn_hit   = (t_x >= wh_x) || (t_x <= wl_x);
  assign warn_clear = (t_x < wh_x - h_x) && (t_x > wl_x + h_x);
  assign crit_clear = (t_x < ch_x - h_x) && (t_x > cl_x + h_x);

  // Saturating error run
  assign count_inc = (cur.count == CNT_MAX) ? CNT_MAX : cur.count + 1'b1;

  always_comb begin
    nxt = cur;
    priority if (opcode == OP_RESET) begin
      nxt.level = ST_NORMAL;
      nxt.count = '0;
    end else if (!checksum_ok) begin
      nxt.count = count_inc;
      if (count_inc >= max_bad_checksums) begin
        nxt.level = ST_FAULT;
      end
    end else begin
      nxt.count = '0;
      unique case (cur.level)
        ST_NORMAL: begin
          if (crit_hit) begin
            nxt.level = ST_CRITICAL;
          end else if (warn_hit) begin
            nxt.level = ST_WARNING;
          end
        end
        ST_WARNING: begin
          if (crit_hit) begin
            nxt.level = ST_CRITICAL;
          end else if (warn_clear) begin
            nxt.level = ST_NORMAL;
          end
        end
        ST_CRITICAL: begin
          if (crit_clear) begin
            nxt.level = ST_WARNING;
          end
        end
        ST_FAULT: begin
          nxt.level = ST_FAULT;
        end
        default: begin
          nxt.level = cur.level;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/temperature_alarm_hysteresis.sv
// ----------------------------------------------------------------------------
// temperature_alarm_hysteresis
// Threshold alarm with hysteresis and a checksum error fault latch.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (opcode, checksum_ok, temperature) arrive on a valid/ready
//   channel; each produces exactly one result word (level,
//   bad_checksum_count) on the output valid/ready channel, in order.
//   A word is captured in an input register, evaluated against the alarm
//   state in one pass and written to the result register once that register
//   is empty or its result is being taken.
//   Throughput is one word per cycle while the receiver keeps taking results;
//   the state update between the two registers is combinational.
//   When the receiver stalls, the result register holds, the input
//   register fills, and in_ready drops; nothing is lost or repeated.
//   Configuration is written through cfg_write / cfg_index / cfg_data while
//   no word is in flight; indexes beyond the register list are ignored.
//   Synchronous reset restores all thresholds to their defaults, the level
//   to normal, the error run to zero and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_alarm_hysteresis
  import tah_pkg::*;
#(
  parameter int TEMP_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [TEMP_BITS-1:0]         cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic                         checksum_ok,
  input  logic signed [TEMP_BITS-1:0]  temperature,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   level,
  output logic [CNT_W-1:0]             bad_checksum_count
);

  // Configuration registers
  logic signed [TEMP_BITS-1:0] warn_high;
  logic signed [TEMP_BITS-1:0] warn_low;
  logic signed [TEMP_BITS-1:0] crit_high;
  logic signed [TEMP_BITS-1:0] crit_low;
  logic        [CNT_W-1:0]     hysteresis;
  logic        [CNT_W-1:0]     max_bad_checksums;

  // Input register
  logic                        s1_valid;
  logic                        s1_opcode;
  logic                        s1_checksum_ok;
  logic signed [TEMP_BITS-1:0] s1_temperature;

  // Alarm state
  tah_state_t                  state;
  tah_state_t                  state_next;

  logic                        advance;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      warn_high         <= TEMP_BITS'(560);
      warn_low          <= TEMP_BITS'(80);
      crit_high         <= TEMP_BITS'(720);
      crit_low          <= '0;
      hysteresis        <= CNT_W'(32);
      max_bad_checksums <= CNT_W'(3);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WARN_HIGH: warn_high         <= cfg_data;
        CFG_WARN_LOW:  warn_low          <= cfg_data;
        CFG_CRIT_HIGH: crit_high         <= cfg_data;
        CFG_CRIT_LOW:  crit_low          <= cfg_data;
        CFG_HYST:      hysteresis        <= cfg_data[CNT_W-1:0];
        CFG_MAX_BAD:   max_bad_checksums <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Move a word from the input register to the result register
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode      <= opcode;
      s1_checksum_ok <= checksum_ok;
      s1_temperature <= temperature;
    end
  end

  tah_eval #(
    .TEMP_BITS (TEMP_BITS)
  ) u_eval (
    .cur               (state),
    .opcode            (s1_opcode),
    .checksum_ok       (s1_checksum_ok),
    .temperature       (s1_temperature),
    .warn_high         (warn_high),
    .warn_low          (warn_low),
    .crit_high         (crit_high),
    .crit_low          (crit_low),
    .hysteresis        (hysteresis),
    .max_bad_checksums (max_bad_checksums),
    .nxt               (state_next)
  );

  // Advance the alarm state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.level <= ST_NORMAL;
      state.count <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      level              <= level_code(state_next.level);
      bad_checksum_count <= state_next.count;
    end
  end

  // Reset command always reports normal with a cleared count
  a_reset_cmd: assert property (@(posedge clk) disable iff (rst)
    advance && s1_opcode == OP_RESET |=>
      level == LVL_NORMAL && bad_checksum_count == '0)
    else $error("reset command did not clear level and count");

  // Fault only leaves on a reset command
  a_fault_hold: assert property (@(posedge clk) disable iff (rst)
    advance && state.level == ST_FAULT && s1_opcode != OP_RESET |=>
      state.level == ST_FAULT)
    else $error("fault level released without reset command");

  // A failed checksum below saturation bumps the run by one
  a_run_inc: assert property (@(posedge clk) disable iff (rst)
    advance && s1_opcode == OP_READING && !s1_checksum_ok && state.count != CNT_MAX |=>
      state.count == $past(state.count) + 1'b1)
    else $error("error run did not increment");

  // Result register mirrors the state after each update
  a_out_match: assert property (@(posedge clk) disable iff (rst)
    advance |=> bad_checksum_count == state.count && level == level_code(state.level))
    else $error("result word does not match alarm state");

  // No result without a word in the input register
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !s1_valid && (!out_valid || out_ready) |=> !out_valid)
    else $error("result produced without an input word");

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the temperature alarm. A short table of directed
// words runs first, then random phases under several threshold settings.
// Every accepted word is run through a local alarm tracker, and each result
// word is compared field by field, in order, with the tracked level and
// error run, or with the expected word given by a checked table row.
// ----------------------------------------------------------------------------
module tb;
  import tah_pkg::*;

  localparam int TEMP_W      = 12;
  localparam int HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]       lvl;
    logic [CNT_W-1:0] cnt;
  } alarm_word_t;

  typedef enum logic [1:0] {ROW_WORD, ROW_CHECKED, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  op;
    logic                  ok;
    logic [TEMP_W-1:0]     val;
    logic [CFG_IDX_W-1:0]  idx;
    alarm_word_t           want;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [TEMP_W-1:0]           cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic                        opcode = OP_READING;
  logic                        checksum_ok = 1'b0;
  logic signed [TEMP_W-1:0]    temperature = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  level;
  logic [CNT_W-1:0]            bad_checksum_count;

  // Thresholds and limits as last written
  logic signed [TEMP_W-1:0]    th_warn_high = TEMP_W'(560);
  logic signed [TEMP_W-1:0]    th_warn_low  = TEMP_W'(80);
  logic signed [TEMP_W-1:0]    th_crit_high = TEMP_W'(720);
  logic signed [TEMP_W-1:0]    th_crit_low  = '0;
  logic [7:0]                  hyst         = 8'd32;
  logic [7:0]                  max_bad      = 8'd3;

  // Tracked alarm state
  logic [1:0]                  alarm_now = LVL_NORMAL;
  logic [CNT_W-1:0]            fail_run  = '0;

  alarm_word_t                 pending_words[$];
  stim_row_t                   directed_rows[$];
  alarm_word_t                 oldest;

  int mismatches    = 0;
  int cycle_count   = 0;
  int snd_idle_pct  = 0;
  int rcv_idle_pct  = 0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int walk_temp     = 0;

  temperature_alarm_hysteresis #(.TEMP_BITS(TEMP_W)) u_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .opcode             (opcode),
    .checksum_ok        (checksum_ok),
    .temperature        (temperature),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .level              (level),
    .bad_checksum_count (bad_checksum_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  function automatic logic signed [TEMP_W-1:0] clamp_temp(input int v);
    int c;
    c = v;
    if (c > 2047) c = 2047;
    if (c < -2048) c = -2048;
    return c[TEMP_W-1:0];
  endfunction

  // Advance the tracked level and error run by one accepted word
  function automatic void step_alarm(input logic op, input logic ok,
                                     input logic signed [TEMP_W-1:0] t);
    int  tv, wh, wl, ch, cl, h;
    logic crit_hit, warn_hit;
    tv = int'(t);
    wh = int'(th_warn_high);
    wl = int'(th_warn_low);
    ch = int'(th_crit_high);
    cl = int'(th_crit_low);
    h  = int'(hyst);
    crit_hit = (tv >= ch) || (tv <= cl);
    warn_hit = (tv >= wh) || (tv <= wl);
    if (op == OP_RESET) begin
      alarm_now = LVL_NORMAL;
      fail_run  = '0;
    end else if (!ok) begin
      if (fail_run != CNT_MAX) fail_run = fail_run + 1'b1;
      if (fail_run >= max_bad) alarm_now = LVL_FAULT;
    end else begin
      fail_run = '0;
      case (alarm_now)
        LVL_NORMAL: begin
          if (crit_hit) alarm_now = LVL_CRITICAL;
          else if (warn_hit) alarm_now = LVL_WARNING;
        end
        LVL_WARNING: begin
          if (crit_hit) alarm_now = LVL_CRITICAL;
          else if (tv < wh - h && tv > wl + h) alarm_now = LVL_NORMAL;
        end
        LVL_CRITICAL: begin
          // step down one level only
          if (tv < ch - h && tv > cl + h) alarm_now = LVL_WARNING;
        end
        default: ;
      endcase
    end
  endfunction

  // Pick a reading: full range, a random walk, or close to a threshold
  function automatic logic signed [TEMP_W-1:0] pick_temp();
    int         r, base, span;
    logic [31:0] bits;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      bits = $urandom;
      walk_temp = int'($signed(bits[TEMP_W-1:0]));
    end else if (r < 50) begin
      walk_temp = int'(clamp_temp(walk_temp + int'($urandom_range(0, 64)) - 32));
    end else begin
      case ($urandom_range(0, 3))
        0:       base = int'(th_warn_high);
        1:       base = int'(th_warn_low);
        2:       base = int'(th_crit_high);
        default: base = int'(th_crit_low);
      endcase
      span = int'(hyst) + 8;
      walk_temp = int'(clamp_temp(base + int'($urandom_range(0, 2 * span)) - span));
    end
    return walk_temp[TEMP_W-1:0];
  endfunction

  // Offer one word, hold it until accepted, then queue its expected result
  task automatic send_word(input logic op, input logic ok, input logic signed [TEMP_W-1:0] t,
                           input logic typed, input alarm_word_t want);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    checksum_ok <= ok;
    temperature <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step_alarm(op, ok, t);
    if (typed) pending_words.push_back(want);
    else pending_words.push_back({alarm_now, fail_run});
  endtask

  // Drop valid and wait until every result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_WARN_HIGH: th_warn_high = data;
      CFG_WARN_LOW:  th_warn_low  = data;
      CFG_CRIT_HIGH: th_crit_high = data;
      CFG_CRIT_LOW:  th_crit_low  = data;
      CFG_HYST:      hyst         = data[7:0];
      CFG_MAX_BAD:   max_bad      = data[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input int wh, input int wl, input int ch, input int cl,
                                input int h, input int mb);
    wait_drained();
    write_reg(CFG_WARN_HIGH, clamp_temp(wh));
    write_reg(CFG_WARN_LOW,  clamp_temp(wl));
    write_reg(CFG_CRIT_HIGH, clamp_temp(ch));
    write_reg(CFG_CRIT_LOW,  clamp_temp(cl));
    write_reg(CFG_HYST,      TEMP_W'(h & 8'hFF));
    write_reg(CFG_MAX_BAD,   TEMP_W'(mb & 8'hFF));
    cfg_write <= 1'b0;
  endtask

  task automatic add_word(input logic op, input logic ok, input int t);
    directed_rows.push_back({ROW_WORD, op, ok, clamp_temp(t), {CFG_IDX_W{1'b0}},
                             {LVL_NORMAL, {CNT_W{1'b0}}}});
  endtask

  task automatic add_checked(input logic op, input logic ok, input int t,
                             input logic [1:0] lvl, input int cnt);
    directed_rows.push_back({ROW_CHECKED, op, ok, clamp_temp(t), {CFG_IDX_W{1'b0}},
                             {lvl, cnt[CNT_W-1:0]}});
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
    directed_rows.push_back({ROW_CFG, OP_READING, 1'b0, data[TEMP_W-1:0], idx,
                             {LVL_NORMAL, {CNT_W{1'b0}}}});
  endtask

  // Receive result words and compare them with the oldest expectation
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected result word, level", int'(level), -1);
      end else begin
        oldest = pending_words.pop_front();
        if (level !== oldest.lvl)
          report_mismatch("level", int'(level), int'(oldest.lvl));
        if (bad_checksum_count !== oldest.cnt)
          report_mismatch("bad_checksum_count", int'(bad_checksum_count),
                          int'(oldest.cnt));
      end
    end
  end

  initial begin
    stim_row_t        row;
    logic             in_cfg;
    logic             op, ok;
    logic signed [TEMP_W-1:0] t;
    logic [31:0]      bits;
    int               ph, i, r, burst_left, reset_pct, c, wl, cl, wh, ch, h, mb, cap;

    // Directed words under the reset thresholds
    add_checked(OP_READING, 1'b1, 300, LVL_NORMAL, 0);
    add_word(OP_READING, 1'b1, 560);
    add_checked(OP_READING, 1'b1, 2047, LVL_CRITICAL, 0);
    add_word(OP_READING, 1'b1, 700);      // inside the hysteresis band, hold
    add_word(OP_READING, 1'b1, 300);      // critical steps down to warning only
    add_word(OP_READING, 1'b1, 300);
    add_checked(OP_READING, 1'b1, -2048, LVL_CRITICAL, 0);
    add_word(OP_READING, 1'b0, 0);
    add_word(OP_READING, 1'b0, 2047);
    add_checked(OP_READING, 1'b0, -2048, LVL_FAULT, 3);
    add_checked(OP_READING, 1'b1, 300, LVL_FAULT, 0);   // fault holds on a good reading
    add_checked(OP_RESET, 1'b0, -2048, LVL_NORMAL, 0);
    add_word(OP_READING, 1'b1, 80);
    add_word(OP_READING, 1'b1, 113);
    add_checked(OP_RESET, 1'b1, 2047, LVL_NORMAL, 0);
    // Limit of zero: any failed checksum latches fault
    add_cfg(CFG_MAX_BAD, 0);
    add_cfg(CFG_HYST, 0);
    add_checked(OP_READING, 1'b0, 300, LVL_FAULT, 1);
    add_checked(OP_RESET, 1'b0, 0, LVL_NORMAL, 0);
    // Inconsistent warning thresholds, widest critical band
    add_cfg(CFG_WARN_HIGH, 100);
    add_cfg(CFG_WARN_LOW, 200);
    add_cfg(CFG_CRIT_HIGH, 2047);
    add_cfg(CFG_CRIT_LOW, -2048);
    add_cfg(CFG_HYST, 255);
    add_cfg(CFG_MAX_BAD, 255);
    add_word(OP_READING, 1'b1, 150);
    add_word(OP_READING, 1'b1, 150);
    add_checked(OP_READING, 1'b1, 2047, LVL_CRITICAL, 0);
    add_checked(OP_READING, 1'b1, -2048, LVL_CRITICAL, 0);
    add_word(OP_READING, 1'b0, 0);
    add_checked(OP_RESET, 1'b1, 0, LVL_NORMAL, 0);

    snd_idle_pct = 19;
    rcv_idle_pct = 64;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    in_cfg = 1'b0;
    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_CFG) begin
        if (!in_cfg) wait_drained();
        in_cfg = 1'b1;
        write_reg(row.idx, row.val);
      end else begin
        if (in_cfg) cfg_write <= 1'b0;
        in_cfg = 1'b0;
        send_word(row.op, row.ok, row.val, row.kind == ROW_CHECKED, row.want);
      end
    end

    // Random phases, each under its own settings
    burst_left = 0;
    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: apply_settings(560, 80, 720, 0, 32, 3);
        1: apply_settings(2047, -2048, 2047, -2048, 255, 255);
        2: apply_settings(-2048, 2047, -2048, 2047, 0, 1);
        default: begin
          c  = int'($urandom_range(0, 3000)) - 1500;
          wl = c - int'($urandom_range(16, 300));
          cl = wl - int'($urandom_range(0, 300));
          wh = c + int'($urandom_range(16, 300));
          ch = wh + int'($urandom_range(0, 300));
          if (ph % 3 == 0) begin
            wl = int'($urandom_range(0, 4095)) - 2048;
            cl = int'($urandom_range(0, 4095)) - 2048;
            wh = int'($urandom_range(0, 4095)) - 2048;
            ch = int'($urandom_range(0, 4095)) - 2048;
          end
          h  = (ph == 8) ? $urandom_range(128, 255) : $urandom_range(0, 64);
          mb = (ph == 9) ? $urandom_range(100, 255) : $urandom_range(1, 6);
          apply_settings(wh, wl, ch, cl, h, mb);
        end
      endcase

      if (ph < 4) begin
        snd_idle_pct = 19;
        rcv_idle_pct = 64;
      end else if (ph < 7) begin
        snd_idle_pct = 64;
        rcv_idle_pct = 19;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end

      for (i = 0; i < 110; i++) begin
        // one run long enough to saturate the error counter
        if (ph == 1 && i == 20) burst_left = 260;
        // stall the receiver while words keep coming
        if (ph == 5 && i == 40) hold_asked <= hold_asked + 1;
        // pause the sender until everything is back
        if (ph == 5 && i == 80) wait_drained();

        bits = $urandom;
        t = bits[TEMP_W-1:0];
        ok = bits[TEMP_W];
        op = OP_READING;
        if (burst_left > 0) begin
          ok = 1'b0;
          burst_left--;
        end else begin
          r = $urandom_range(0, 99);
          reset_pct = (alarm_now == LVL_FAULT) ? 25 : 3;
          if (r < reset_pct) begin
            op = OP_RESET;
          end else if (r < reset_pct + 6) begin
            cap = (max_bad > 10) ? 10 : max_bad;
            burst_left = $urandom_range(0, cap + 1);
            ok = 1'b0;
          end else begin
            ok = 1'b1;
            t = pick_temp();
          end
        end
        send_word(op, ok, t, 1'b0, {LVL_NORMAL, {CNT_W{1'b0}}});
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
